// ===== design/akf_pkg.sv =====
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, scratch memory map and helpers of the altitude filter.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int COV_FRAC_BITS_DEF = 24;
    localparam int WORD_W            = 32;
    localparam int CFG_W             = 31;
    localparam int CFG_INDEX_W       = 3;
    localparam int QUOT_W            = 32;
    localparam int DEN_W             = 64;
    localparam int MS_PER_S          = 1000;

    localparam int RAM_DEPTH   = 43;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int STATE_WORDS = 12;
    localparam int STATE_IDX_W = $clog2(STATE_WORDS);

    typedef logic [ADDR_W-1:0] addr_t;

    localparam addr_t A_X   = addr_t'(0);
    localparam addr_t A_P   = addr_t'(3);
    localparam addr_t A_FP  = addr_t'(12);
    localparam addr_t A_PP  = addr_t'(21);
    localparam addr_t A_XP  = addr_t'(30);
    localparam addr_t A_G0  = addr_t'(33);
    localparam addr_t A_G1  = addr_t'(36);
    localparam addr_t A_E0  = addr_t'(39);
    localparam addr_t A_E1  = addr_t'(40);
    localparam addr_t A_S00 = addr_t'(41);
    localparam addr_t A_S11 = addr_t'(42);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_Q_HEIGHT,
        CFG_Q_VELOCITY,
        CFG_Q_ACCEL,
        CFG_R_HEIGHT,
        CFG_R_ACCEL
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DT,
        PH_F2,
        PH_XP,
        PH_FP,
        PH_PP,
        PH_S,
        PH_DET,
        PH_NUM,
        PH_DIV,
        PH_ERR,
        PH_UPX,
        PH_UPP,
        PH_COPY,
        PH_OUT
    } phase_t;

    typedef enum logic [1:0] {
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_WR
    } step_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_COV,
        SH_COV1
    } shift_t;

    typedef enum logic [1:0] {
        D_RAM,
        D_F2,
        D_DET,
        D_NUM
    } dest_t;

    typedef enum logic [2:0] {
        I_ZERO,
        I_QH,
        I_QV,
        I_QA,
        I_RH,
        I_RA,
        I_MH,
        I_MA
    } init_t;

    typedef struct packed {
        logic   a_is_f;
        logic   [3:0] a_fidx;
        addr_t  a_addr;
        logic   b_is_f;
        logic   [3:0] b_fidx;
        addr_t  b_addr;
        logic   is_add;
        logic   neg;
        shift_t shift;
        logic   last;
        dest_t  dest;
        addr_t  dest_addr;
        init_t  init;
    } term_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [1:0] grp_row(input logic [3:0] g);
        logic [1:0] r;
        case (g)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] grp_col(input logic [3:0] g);
        logic [1:0] c;
        case (g)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/altitude_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// altitude_kalman_filter_top
// Three-state altitude Kalman filter, memory-based sequencer.
// ----------------------------------------------------------------------------
// One item runs predict, innovation inversion and update (when the innovation
// determinant is zero, the predicted state and covariance are copied instead),
// and the output register may wait on out_ready. The run time is set by the
// single shared multiplier, which reads each product term from the scratch RAM
// and writes each result word back, and by the one-bit-per-cycle divider, run
// once for each of the six gains. dt is formed from step_ms in the PH_DT state
// by reciprocal multiplication. One item is in work at a time; a new item is
// taken as soon as the previous result is parked in the output register.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_top #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [31:0]              meas_height,
    input  logic signed [31:0]              meas_accel,
    input  logic [15:0]                     step_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              est_height,
    output logic signed [31:0]              est_velocity,
    output logic signed [31:0]              est_accel,
    output logic                            singular,
    input  logic                            cfg_write,
    input  logic [akf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [akf_pkg::CFG_W-1:0]       cfg_data
);

    import akf_pkg::*;

    localparam int DW = 64 + COV_FRAC_BITS;
    localparam logic [63:0] FX_ONE64 = 64'd1 << COV_FRAC_BITS;
    localparam logic [WORD_W-1:0] FX_ONE = WORD_W'(FX_ONE64);
    localparam logic [WORD_W-1:0] P_INIT = WORD_W'((FX_ONE64 + 64'd50) / 64'd100);
    localparam logic [CFG_W-1:0] QH_RST = CFG_W'((FX_ONE64 + 64'd500000) / 64'd1000000);
    localparam logic [CFG_W-1:0] QA_RST =
        CFG_W'((FX_ONE64 * 64'd100000 + 64'd500000) / 64'd1000000);
    localparam logic [CFG_W-1:0] RH_RST =
        CFG_W'((FX_ONE64 * 64'd1000 + 64'd500000) / 64'd1000000);
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
    localparam logic signed [65:0] HALF_COV  = 66'sd1 <<< (COV_FRAC_BITS - 1);
    localparam logic signed [65:0] HALF_COV1 = 66'sd1 <<< COV_FRAC_BITS;

    // dt = ms * 2^cov / 1000 split into whole part and remainder part
    localparam int          DT_SHIFT = 36;
    localparam logic [63:0] DT_K = FX_ONE64 / 64'(MS_PER_S);
    localparam logic [25:0] DT_R = 26'(FX_ONE64 % 64'(MS_PER_S));
    localparam logic [26:0] DT_M =
        27'(((64'd1 << DT_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

    function automatic logic [WORD_W-1:0] sat32(input logic signed [65:0] v);
        logic [WORD_W-1:0] r;
        if (v > SAT_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'h8000_0000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] f_val(input logic [3:0] idx,
                                                 input logic [WORD_W-1:0] dtv,
                                                 input logic [WORD_W-1:0] f2v);
        logic [WORD_W-1:0] r;
        case (idx)
            4'd0, 4'd4, 4'd8: r = FX_ONE;
            4'd1, 4'd5:       r = dtv;
            4'd2:             r = f2v;
            default:          r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] fid(input logic [1:0] r, input logic [1:0] c);
        return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic addr_t tri3(input logic [1:0] r);
        return addr_t'({r, 1'b0}) + addr_t'(r);
    endfunction

    // control state
    phase_t     phase_reg, phase_next;
    step_t      step_reg, step_next;
    logic [3:0] grp_reg, grp_next;
    logic [1:0] k_reg, k_next;

    // configuration
    logic [CFG_W-1:0] q_height_reg, q_velocity_reg, q_accel_reg;
    logic [CFG_W-1:0] r_height_reg, r_accel_reg;

    // datapath
    logic signed [31:0] mh_reg, ma_reg;
    logic [15:0]        ms_reg;
    logic [WORD_W-1:0]  dt_reg, f2_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic [63:0]        det_reg, num_reg;
    logic               sing_reg;
    logic [WORD_W-1:0]  xw_reg [3];
    logic [STATE_WORDS-1:0] valid_reg;
    addr_t              ra_reg, rb_reg;

    logic               out_valid_reg;
    logic signed [31:0] est_height_reg, est_velocity_reg, est_accel_reg;
    logic               singular_reg;

    term_t              t;
    logic [1:0]         rw, cl;
    logic               wr_en, cap_f2, cap_det, cap_num, out_load, div_start;
    addr_t              wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               term_phase;

    logic [WORD_W-1:0]  ram_qa, ram_qb;
    logic signed [31:0] rd_a, rd_b, opa, opb;
    logic signed [65:0] init_val, p66, tv;

    logic [25:0]        dt_num;
    logic [52:0]        dt_prod;
    logic [63:0]        dt_full;
    logic [WORD_W-1:0]  dt_calc;

    logic [DW-1:0]      div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [QUOT_W-1:0]  div_q;
    div_status_t        div_st;
    logic [63:0]        num_mag, det_mag;
    logic [WORD_W-1:0]  gain;

    assign term_phase = (phase_reg != PH_IDLE) && (phase_reg != PH_DT) &&
                        (phase_reg != PH_DIV) && (phase_reg != PH_OUT);
    assign in_ready   = (phase_reg == PH_IDLE);

    // term descriptor
    always_comb
    begin
        t  = '0;
        rw = grp_row(grp_reg);
        cl = grp_col(grp_reg);
        case (phase_reg)
            PH_F2:
            begin
                t.a_is_f = 1'b1;
                t.a_fidx = 4'd1;
                t.b_is_f = 1'b1;
                t.b_fidx = 4'd1;
                t.shift  = SH_COV1;
                t.last   = 1'b1;
                t.dest   = D_F2;
            end
            PH_XP:
            begin
                t.a_is_f    = 1'b1;
                t.a_fidx    = fid(grp_reg[1:0], k_reg);
                t.b_addr    = A_X + addr_t'(k_reg);
                t.shift     = SH_COV;
                t.last      = (k_reg == 2'd2);
                t.dest_addr = A_XP + addr_t'(grp_reg);
            end
            PH_FP:
            begin
                t.a_is_f    = 1'b1;
                t.a_fidx    = fid(rw, k_reg);
                t.b_addr    = A_P + tri3(k_reg) + addr_t'(cl);
                t.shift     = SH_COV;
                t.last      = (k_reg == 2'd2);
                t.dest_addr = A_FP + addr_t'(grp_reg);
            end
            PH_PP:
            begin
                t.a_is_f    = 1'b1;
                t.a_fidx    = fid(cl, k_reg);
                t.b_addr    = A_FP + tri3(rw) + addr_t'(k_reg);
                t.shift     = SH_COV;
                t.last      = (k_reg == 2'd2);
                t.dest_addr = A_PP + addr_t'(grp_reg);
                if (rw == cl)
                    t.init = (rw == 2'd0) ? I_QH : ((rw == 2'd1) ? I_QV : I_QA);
            end
            PH_S:
            begin
                t.is_add    = 1'b1;
                t.b_addr    = grp_reg[0] ? (A_PP + addr_t'(8)) : A_PP;
                t.init      = grp_reg[0] ? I_RA : I_RH;
                t.last      = 1'b1;
                t.dest_addr = A_S00 + addr_t'(grp_reg[0]);
            end
            PH_DET:
            begin
                t.a_addr = k_reg[0] ? (A_PP + addr_t'(2)) : A_S00;
                t.b_addr = k_reg[0] ? (A_PP + addr_t'(6)) : A_S11;
                t.neg    = k_reg[0];
                t.last   = k_reg[0];
                t.dest   = D_DET;
            end
            PH_NUM:
            begin
                t.neg  = k_reg[0];
                t.last = k_reg[0];
                t.dest = D_NUM;
                if (!grp_reg[0])
                begin
                    t.a_addr = A_PP + tri3(grp_reg[2:1]) + (k_reg[0] ? addr_t'(2) : '0);
                    t.b_addr = k_reg[0] ? (A_PP + addr_t'(6)) : A_S11;
                end
                else
                begin
                    t.a_addr = A_PP + tri3(grp_reg[2:1]) + (k_reg[0] ? '0 : addr_t'(2));
                    t.b_addr = k_reg[0] ? (A_PP + addr_t'(2)) : A_S00;
                end
            end
            PH_ERR:
            begin
                t.is_add    = 1'b1;
                t.neg       = 1'b1;
                t.b_addr    = grp_reg[0] ? (A_XP + addr_t'(2)) : A_XP;
                t.init      = grp_reg[0] ? I_MA : I_MH;
                t.last      = 1'b1;
                t.dest_addr = A_E0 + addr_t'(grp_reg[0]);
            end
            PH_UPX:
            begin
                t.last      = (k_reg == 2'd2);
                t.dest_addr = A_X + addr_t'(grp_reg);
                case (k_reg)
                    2'd0:
                    begin
                        t.is_add = 1'b1;
                        t.b_addr = A_XP + addr_t'(grp_reg);
                    end
                    2'd1:
                    begin
                        t.a_addr = A_G0 + addr_t'(grp_reg);
                        t.b_addr = A_E0;
                        t.shift  = SH_COV;
                    end
                    default:
                    begin
                        t.a_addr = A_G1 + addr_t'(grp_reg);
                        t.b_addr = A_E1;
                        t.shift  = SH_COV;
                    end
                endcase
            end
            PH_UPP:
            begin
                t.last      = (k_reg == 2'd2);
                t.dest_addr = A_P + addr_t'(grp_reg);
                case (k_reg)
                    2'd0:
                    begin
                        t.is_add = 1'b1;
                        t.b_addr = A_PP + addr_t'(grp_reg);
                    end
                    2'd1:
                    begin
                        t.neg    = 1'b1;
                        t.a_addr = A_G0 + addr_t'(rw);
                        t.b_addr = A_PP + addr_t'(cl);
                        t.shift  = SH_COV;
                    end
                    default:
                    begin
                        t.neg    = 1'b1;
                        t.a_addr = A_G1 + addr_t'(rw);
                        t.b_addr = A_PP + addr_t'(6) + addr_t'(cl);
                        t.shift  = SH_COV;
                    end
                endcase
            end
            PH_COPY:
            begin
                t.is_add    = 1'b1;
                t.b_addr    = (grp_reg < 4'd3) ? (A_XP + addr_t'(grp_reg))
                                               : (A_PP + addr_t'(grp_reg) - addr_t'(3));
                t.last      = 1'b1;
                t.dest_addr = A_X + addr_t'(grp_reg);
            end
            default:
            begin
                t = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= ST_RD;
            grp_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            grp_reg   <= grp_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        grp_next   = grp_reg;
        k_next     = k_reg;
        wr_en      = 1'b0;
        cap_f2     = 1'b0;
        cap_det    = 1'b0;
        cap_num    = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        wr_addr    = t.dest_addr;
        wr_data    = sat32(acc_reg);
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    phase_next = PH_DT;
                    step_next  = ST_RD;
                end
            end
            PH_DT:
            begin
                phase_next = PH_F2;
                step_next  = ST_RD;
                grp_next   = '0;
                k_next     = '0;
            end
            PH_DIV:
            begin
                wr_addr = (grp_reg[0] ? A_G1 : A_G0) + addr_t'(grp_reg[2:1]);
                wr_data = gain;
                if (step_reg == ST_RD)
                begin
                    div_start = 1'b1;
                    step_next = ST_MUL;
                end
                else if (div_st.done)
                begin
                    wr_en     = 1'b1;
                    step_next = ST_RD;
                    k_next    = '0;
                    if (grp_reg == 4'd5)
                    begin
                        phase_next = PH_ERR;
                        grp_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_NUM;
                        grp_next   = grp_reg + 4'd1;
                    end
                end
            end
            PH_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                case (step_reg)
                    ST_RD:  step_next = ST_MUL;
                    ST_MUL: step_next = ST_ACC;
                    ST_ACC:
                    begin
                        if (t.last)
                            step_next = ST_WR;
                        else
                        begin
                            k_next    = k_reg + 2'd1;
                            step_next = ST_RD;
                        end
                    end
                    default:
                    begin
                        k_next    = '0;
                        step_next = ST_RD;
                        grp_next  = grp_reg + 4'd1;
                        case (t.dest)
                            D_RAM:   wr_en   = 1'b1;
                            D_F2:    cap_f2  = 1'b1;
                            D_DET:   cap_det = 1'b1;
                            default: cap_num = 1'b1;
                        endcase
                        case (phase_reg)
                            PH_F2:
                            begin
                                phase_next = PH_XP;
                                grp_next   = '0;
                            end
                            PH_XP, PH_UPX:
                            begin
                                if (grp_reg == 4'd2)
                                begin
                                    phase_next = (phase_reg == PH_XP) ? PH_FP : PH_UPP;
                                    grp_next   = '0;
                                end
                            end
                            PH_FP, PH_PP, PH_UPP:
                            begin
                                if (grp_reg == 4'd8)
                                begin
                                    grp_next = '0;
                                    case (phase_reg)
                                        PH_FP:   phase_next = PH_PP;
                                        PH_PP:   phase_next = PH_S;
                                        default: phase_next = PH_OUT;
                                    endcase
                                end
                            end
                            PH_S, PH_ERR:
                            begin
                                if (grp_reg == 4'd1)
                                begin
                                    phase_next = (phase_reg == PH_S) ? PH_DET : PH_UPX;
                                    grp_next   = '0;
                                end
                            end
                            PH_DET:
                            begin
                                grp_next   = '0;
                                phase_next = (acc_reg[63:0] == '0) ? PH_COPY : PH_NUM;
                            end
                            PH_NUM:
                            begin
                                grp_next   = grp_reg;
                                phase_next = PH_DIV;
                            end
                            default:
                            begin
                                if (grp_reg == 4'd11)
                                begin
                                    phase_next = PH_OUT;
                                    grp_next   = '0;
                                end
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_height_reg   <= QH_RST;
            q_velocity_reg <= '0;
            q_accel_reg    <= QA_RST;
            r_height_reg   <= RH_RST;
            r_accel_reg    <= QA_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_Q_HEIGHT:   q_height_reg   <= cfg_data;
                CFG_Q_VELOCITY: q_velocity_reg <= cfg_data;
                CFG_Q_ACCEL:    q_accel_reg    <= cfg_data;
                CFG_R_HEIGHT:   r_height_reg   <= cfg_data;
                CFG_R_ACCEL:    r_accel_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // scratch memory
    akf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (t.a_addr),
        .raddr_b (t.b_addr),
        .rdata_a (ram_qa),
        .rdata_b (ram_qb)
    );

    // unwritten state words read as their reset value
    always_comb
    begin
        if ((ra_reg < addr_t'(STATE_WORDS)) && !valid_reg[ra_reg[STATE_IDX_W-1:0]])
            rd_a = ((ra_reg == A_P) || (ra_reg == A_P + addr_t'(4)) ||
                    (ra_reg == A_P + addr_t'(8))) ? P_INIT : '0;
        else
            rd_a = ram_qa;
        if ((rb_reg < addr_t'(STATE_WORDS)) && !valid_reg[rb_reg[STATE_IDX_W-1:0]])
            rd_b = ((rb_reg == A_P) || (rb_reg == A_P + addr_t'(4)) ||
                    (rb_reg == A_P + addr_t'(8))) ? P_INIT : '0;
        else
            rd_b = ram_qb;
    end

    assign opa = t.a_is_f ? f_val(t.a_fidx, dt_reg, f2_reg) : rd_a;
    assign opb = t.b_is_f ? f_val(t.b_fidx, dt_reg, f2_reg) : rd_b;

    always_comb
    begin
        case (t.init)
            I_QH:    init_val = {35'd0, q_height_reg};
            I_QV:    init_val = {35'd0, q_velocity_reg};
            I_QA:    init_val = {35'd0, q_accel_reg};
            I_RH:    init_val = {35'd0, r_height_reg};
            I_RA:    init_val = {35'd0, r_accel_reg};
            I_MH:    init_val = {{34{mh_reg[31]}}, mh_reg};
            I_MA:    init_val = {{34{ma_reg[31]}}, ma_reg};
            default: init_val = '0;
        endcase
    end

    assign p66 = {{2{prod_reg[63]}}, prod_reg};

    always_comb
    begin
        case (t.shift)
            SH_COV:  tv = (p66 + HALF_COV) >>> COV_FRAC_BITS;
            SH_COV1: tv = (p66 + HALF_COV1) >>> (COV_FRAC_BITS + 1);
            default: tv = p66;
        endcase
    end

    // dt, rounded, by reciprocal multiplication of the remainder part
    assign dt_num  = 26'(ms_reg) * DT_R + 26'(MS_PER_S / 2);
    assign dt_prod = 53'(dt_num) * 53'(DT_M);
    assign dt_full = 64'(ms_reg) * DT_K + 64'(dt_prod[52:DT_SHIFT]);
    assign dt_calc = (dt_full > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dt_full[WORD_W-1:0];

    // divider operands
    assign num_mag = num_reg[63] ? (~num_reg + 64'd1) : num_reg;
    assign det_mag = det_reg[63] ? (~det_reg + 64'd1) : det_reg;
    assign gain    = (num_reg[63] ^ det_reg[63]) ? (~div_q + 32'd1) : div_q;

    assign div_dividend = DW'(num_mag) << COV_FRAC_BITS;
    assign div_divisor  = det_mag;

    akf_div #(
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .status   (div_st)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        ra_reg <= t.a_addr;
        rb_reg <= t.b_addr;
        if (in_valid && in_ready)
        begin
            mh_reg <= meas_height;
            ma_reg <= meas_accel;
            ms_reg <= step_ms;
        end
        if (phase_reg == PH_DT)
            dt_reg <= dt_calc;
        if (term_phase && (step_reg == ST_RD) && (k_reg == 2'd0))
            acc_reg <= init_val;
        else if (term_phase && (step_reg == ST_ACC))
            acc_reg <= t.neg ? (acc_reg - tv) : (acc_reg + tv);
        if (term_phase && (step_reg == ST_MUL))
            prod_reg <= t.is_add ? $signed({{32{opb[31]}}, opb}) : (opa * opb);
        if (cap_f2)
            f2_reg <= sat32(acc_reg);
        if (cap_det)
            det_reg <= acc_reg[63:0];
        if (cap_num)
            num_reg <= acc_reg[63:0];
        if (wr_en && (wr_addr < addr_t'(3)))
            xw_reg[wr_addr[1:0]] <= wr_data;
        if (out_load)
        begin
            est_height_reg   <= xw_reg[0];
            est_velocity_reg <= xw_reg[1];
            est_accel_reg    <= xw_reg[2];
            singular_reg     <= sing_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr < addr_t'(STATE_WORDS)))
                valid_reg[wr_addr[STATE_IDX_W-1:0]] <= 1'b1;
            if (cap_det)
                sing_reg <= (acc_reg[63:0] == '0);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign est_height   = est_height_reg;
    assign est_velocity = est_velocity_reg;
    assign est_accel    = est_accel_reg;
    assign singular     = singular_reg;

    // checks
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg == PH_OUT))
        else $error("result raised outside output phase");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr < addr_t'(RAM_DEPTH)))
        else $error("scratch write out of range");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (phase_reg == PH_DT))
        else $error("accepted item did not start work");

endmodule

// ===== design/akf_ram.sv =====
// ----------------------------------------------------------------------------
// akf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module akf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/akf_div.sv =====
// ----------------------------------------------------------------------------
// akf_div
// Unsigned shift-subtract divider, one quotient bit per cycle, clamped.
// ----------------------------------------------------------------------------
module akf_div #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [64+COV_FRAC_BITS-1:0]   dividend,
    input  logic [akf_pkg::DEN_W-1:0]     divisor,
    output logic [akf_pkg::QUOT_W-1:0]    quotient,
    output akf_pkg::div_status_t          status
);

    import akf_pkg::*;

    localparam int DW = 64 + COV_FRAC_BITS;
    localparam int SW = DEN_W + QUOT_W - 1;
    localparam int RW = (DW > SW) ? DW : SW;
    localparam int CW = $clog2(QUOT_W + 1);

    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     ds_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic              busy;
    logic              ge;

    assign busy = (cnt_reg != '0);
    assign ge   = (rem_reg >= ds_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(QUOT_W);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(dividend);
            ds_reg  <= RW'(divisor) << (QUOT_W - 1);
            q_reg   <= '0;
        end
        else if (busy)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - ds_reg;
            end
            q_reg  <= {q_reg[QUOT_W-2:0], ge};
            ds_reg <= ds_reg >> 1;
        end
    end

    assign quotient    = q_reg[QUOT_W-1] ? {1'b0, {(QUOT_W-1){1'b1}}} : q_reg;
    assign status.busy = busy;
    assign status.done = done_reg;

endmodule
